FILE: hw/rtl/selsort_pkg.sv
// Shared types and constants for the selection sorter.
// Holds the item structs, the cell control bundle and the sequencer states.
// No dependencies.
package selsort_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_ITEMS_DEF  = 32;
    localparam int DATA_WIDTH_DEF = 32;

    // Width of the value fields on the ports
    localparam int VALUE_W = 32;

    // Input item
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } in_item_t;

    // Result item
    typedef struct packed {
        logic signed [VALUE_W-1:0] sorted_value;
        logic                      final_res;
        logic                      overflowed;
    } out_item_t;

    // Per-cell control from the sequencer
    typedef struct packed {
        logic shift;   // load from left neighbor (or the new item at cell 0)
        logic take;    // this cell's entry was just emitted
        logic clear;   // block done, release all entries
        logic member;  // cell holds an entry of the current block
    } cell_ctrl_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_SCAN,
        ST_EMIT
    } sort_state_t;

endpackage

FILE: hw/rtl/selection_sorter_core.sv
// Selection sorter: collects a block of signed values, emits them ascending.
//
// Input channel s_valid/s_ready/s_data carries one value per item; the item
// with last set closes the block. Up to MAX_ITEMS values are kept; further
// items of the same block are dropped and every result of that block then
// carries overflowed. Result channel m_valid/m_ready/m_data gives the values
// in ascending order, final_res set on the last one.
// Loading accepts one item per cycle. After the last item, each result needs
// one pass of the minimum wavefront down the chain of MAX_ITEMS cells, then
// it is shown until taken; the chain length sets the pass time. s_ready is low
// from the last item until the final result is taken. A stalled receiver
// simply holds the sorter in its current result; nothing is lost. Reset
// (aresetn low, synchronous) empties the block and drops any pending results;
// no clearing pass is needed.
// Depends on selsort_pkg and selsort_cell.
module selection_sorter_core #(
    parameter int MAX_ITEMS  = selsort_pkg::MAX_ITEMS_DEF,
    parameter int DATA_WIDTH = selsort_pkg::DATA_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  selsort_pkg::in_item_t  s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output selsort_pkg::out_item_t m_data
);

    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam logic [CNT_W-1:0] CAP       = CNT_W'(MAX_ITEMS);
    localparam logic [IDX_W-1:0] WAIT_LAST = IDX_W'(MAX_ITEMS - 1);

    selsort_pkg::sort_state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] emitted_reg, emitted_next;
    logic [IDX_W-1:0] wait_reg, wait_next;
    logic             ovf_reg, ovf_next;

    logic                  in_acc, out_acc, do_shift, do_clear, is_final;
    logic [63:0]           wide_in;
    logic [63:0]           wide_out;
    logic [DATA_WIDTH-1:0] in_val;

    logic [DATA_WIDTH-1:0] store_val [MAX_ITEMS];
    logic [DATA_WIDTH-1:0] cand_val  [MAX_ITEMS];
    logic [IDX_W-1:0]      cand_idx  [MAX_ITEMS];
    logic                  cand_ok   [MAX_ITEMS];

    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;

    // Input value at store width (zero-extended past 32 bits)
    assign wide_in = 64'({32'b0, s_data.value});
    assign in_val  = wide_in[DATA_WIDTH-1:0];

    assign do_shift = in_acc && (count_reg < CAP);
    assign is_final = (CNT_W'(emitted_reg + 1'b1) == count_reg);
    assign do_clear = out_acc && is_final;

    // Sequencer: collect, wait out the wavefront, present result
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        emitted_next = emitted_reg;
        wait_next    = wait_reg;
        ovf_next     = ovf_reg;
        unique case (state_reg)
            selsort_pkg::ST_COLLECT: begin
                if (in_acc) begin
                    if (count_reg < CAP) begin
                        count_next = CNT_W'(count_reg + 1'b1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_data.last) begin
                        state_next   = selsort_pkg::ST_SCAN;
                        wait_next    = '0;
                        emitted_next = '0;
                    end
                end
            end
            selsort_pkg::ST_SCAN: begin
                wait_next = IDX_W'(wait_reg + 1'b1);
                if (wait_reg == WAIT_LAST) begin
                    state_next = selsort_pkg::ST_EMIT;
                end
            end
            selsort_pkg::ST_EMIT: begin
                if (out_acc) begin
                    if (is_final) begin
                        state_next = selsort_pkg::ST_COLLECT;
                        count_next = '0;
                        ovf_next   = 1'b0;
                    end else begin
                        state_next   = selsort_pkg::ST_SCAN;
                        wait_next    = '0;
                        emitted_next = CNT_W'(emitted_reg + 1'b1);
                    end
                end
            end
            default: begin
                state_next = selsort_pkg::ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= selsort_pkg::ST_COLLECT;
            count_reg   <= '0;
            emitted_reg <= '0;
            wait_reg    <= '0;
            ovf_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            emitted_reg <= emitted_next;
            wait_reg    <= wait_next;
            ovf_reg     <= ovf_next;
        end
    end

    // Chain of cells
    for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
        selsort_pkg::cell_ctrl_t ctrl;
        logic [DATA_WIDTH-1:0]   sh_in;
        logic [DATA_WIDTH-1:0]   cv_in;
        logic [IDX_W-1:0]        ci_in;
        logic                    co_in;

        assign ctrl.shift  = do_shift;
        assign ctrl.take   = out_acc && (cand_idx[MAX_ITEMS-1] == IDX_W'(k));
        assign ctrl.clear  = do_clear;
        assign ctrl.member = (CNT_W'(k) < count_reg);

        if (k == 0) begin : g_head
            assign sh_in = in_val;
            assign cv_in = '0;
            assign ci_in = '0;
            assign co_in = 1'b0;
        end else begin : g_body
            assign sh_in = store_val[k-1];
            assign cv_in = cand_val[k-1];
            assign ci_in = cand_idx[k-1];
            assign co_in = cand_ok[k-1];
        end

        selsort_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IDX_W      (IDX_W),
            .CELL_IDX   (k)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .ctrl         (ctrl),
            .shift_in     (sh_in),
            .store_out    (store_val[k]),
            .cand_val_in  (cv_in),
            .cand_idx_in  (ci_in),
            .cand_ok_in   (co_in),
            .cand_val_out (cand_val[k]),
            .cand_idx_out (cand_idx[k]),
            .cand_ok_out  (cand_ok[k])
        );
    end

    // Handshakes and result item from the chain's tail register
    assign s_ready  = (state_reg == selsort_pkg::ST_COLLECT);
    assign m_valid  = (state_reg == selsort_pkg::ST_EMIT);
    assign wide_out = 64'(cand_val[MAX_ITEMS-1]);

    assign m_data.sorted_value = wide_out[selsort_pkg::VALUE_W-1:0];
    assign m_data.final_res    = is_final;
    assign m_data.overflowed   = ovf_reg;

endmodule

FILE: hw/rtl/selsort_cell.sv
// One cell of the sorting chain: holds one stored entry and a taken mark,
// and keeps the smallest untaken candidate seen so far along the chain.
// Depends on selsort_pkg.
module selsort_cell #(
    parameter int DATA_WIDTH = selsort_pkg::DATA_WIDTH_DEF,
    parameter int IDX_W      = 5,
    parameter int CELL_IDX   = 0
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  selsort_pkg::cell_ctrl_t ctrl,
    // shift path for loading
    input  logic [DATA_WIDTH-1:0]   shift_in,
    output logic [DATA_WIDTH-1:0]   store_out,
    // running-minimum path
    input  logic [DATA_WIDTH-1:0]   cand_val_in,
    input  logic [IDX_W-1:0]        cand_idx_in,
    input  logic                    cand_ok_in,
    output logic [DATA_WIDTH-1:0]   cand_val_out,
    output logic [IDX_W-1:0]        cand_idx_out,
    output logic                    cand_ok_out
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [DATA_WIDTH-1:0] entry_reg;
    logic                  taken_reg;
    logic                  taken_next;
    logic [DATA_WIDTH-1:0] cval_reg, cval_next;
    logic [IDX_W-1:0]      cidx_reg, cidx_next;
    logic                  cok_reg, cok_next;
    logic                  eligible;

    // Entry storage, loaded by shifting along the chain
    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            entry_reg <= shift_in;
        end
    end

    // Taken mark
    always_comb begin
        taken_next = taken_reg;
        if (ctrl.clear) begin
            taken_next = 1'b0;
        end else if (ctrl.take) begin
            taken_next = 1'b1;
        end
    end

    // Keep the smaller of the incoming candidate and this entry if it is eligible; a tie keeps the incoming one
    always_comb begin
        eligible  = ctrl.member && !taken_reg;
        cval_next = cand_val_in;
        cidx_next = cand_idx_in;
        cok_next  = cand_ok_in;
        if (eligible && (!cand_ok_in || ($signed(entry_reg) < $signed(cand_val_in)))) begin
            cval_next = entry_reg;
            cidx_next = MY_IDX;
            cok_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            taken_reg <= 1'b0;
            cok_reg   <= 1'b0;
        end else begin
            taken_reg <= taken_next;
            cok_reg   <= cok_next;
        end
    end

    always_ff @(posedge aclk) begin
        cval_reg <= cval_next;
        cidx_reg <= cidx_next;
    end

    assign store_out    = entry_reg;
    assign cand_val_out = cval_reg;
    assign cand_idx_out = cidx_reg;
    assign cand_ok_out  = cok_reg;

endmodule

FILE: tb/selection_sorter_core_tb.sv
// Self-checking testbench for selection_sorter_core: drives blocks of signed
// values, predicts the ascending output in-line and compares every result item.
// Depends on selsort_pkg and the selection_sorter_core RTL.
`timescale 1ns / 1ps

module selection_sorter_core_tb;

    localparam int CAP            = selsort_pkg::MAX_ITEMS_DEF;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int RANDOM_ITEMS   = 400;
    localparam int N_PHASES       = 4;
    localparam int N_DIRECTED     = 19;

    localparam logic signed [selsort_pkg::VALUE_W-1:0] VMAX = 32'sh7FFF_FFFF;
    localparam logic signed [selsort_pkg::VALUE_W-1:0] VMIN = 32'sh8000_0000;

    // One directed row; typed rows are single-item blocks with a known answer
    typedef struct packed {
        logic signed [selsort_pkg::VALUE_W-1:0] value;
        logic                                   last;
        logic                                   typed;
        logic signed [selsort_pkg::VALUE_W-1:0] typed_value;
    } dir_row_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    selsort_pkg::in_item_t  s_data;
    logic                   m_valid;
    logic                   m_ready;
    selsort_pkg::out_item_t m_data;

    // Sorted values still owed by the block, oldest first
    selsort_pkg::out_item_t pending_sorted[$];

    // Shadow of the block's store
    logic signed [selsort_pkg::VALUE_W-1:0] shadow_store [CAP];
    int                                     shadow_count;
    bit                                     shadow_dropped;

    int mismatch_count;
    int quiet_cycles;
    int tx_gap_pct;
    int rx_stall_pct;
    bit hold_req;

    dir_row_t directed_rows [N_DIRECTED] = '{
        '{VMAX,  1'b1, 1'b1, VMAX},
        '{VMIN,  1'b1, 1'b1, VMIN},
        '{32'sd0, 1'b1, 1'b1, 32'sd0},
        '{-32'sd1, 1'b1, 1'b1, -32'sd1},
        // mixed block with a tie and both extremes
        '{32'sd5, 1'b0, 1'b0, 32'sd0},
        '{-32'sd3, 1'b0, 1'b0, 32'sd0},
        '{32'sd5, 1'b0, 1'b0, 32'sd0},
        '{VMIN,  1'b0, 1'b0, 32'sd0},
        '{VMAX,  1'b0, 1'b0, 32'sd0},
        '{32'sd0, 1'b0, 1'b0, 32'sd0},
        '{-32'sd1, 1'b1, 1'b0, 32'sd0},
        // all equal
        '{32'sd7, 1'b0, 1'b0, 32'sd0},
        '{32'sd7, 1'b1, 1'b0, 32'sd0},
        // reversed pair of extremes
        '{VMAX,  1'b0, 1'b0, 32'sd0},
        '{VMIN,  1'b1, 1'b0, 32'sd0},
        // values that differ only near the sign bit
        '{32'sh8000_0001, 1'b0, 1'b0, 32'sd0},
        '{32'sh7FFF_FFFE, 1'b0, 1'b0, 32'sd0},
        '{32'shFFFF_FFFE, 1'b0, 1'b0, 32'sd0},
        '{32'sh0000_0001, 1'b1, 1'b0, 32'sd0}
    };

    selection_sorter_core u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 10 ns clock
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // Store one value; on the closing item, sort the block ascending and
    // return its result items
    function automatic void store_and_sort(input selsort_pkg::in_item_t it,
                                           output selsort_pkg::out_item_t res[$]);
        int                                     best;
        logic signed [selsort_pkg::VALUE_W-1:0] keep;
        selsort_pkg::out_item_t                 r;
        res = {};
        if (shadow_count < CAP) begin
            shadow_store[shadow_count] = it.value;
            shadow_count++;
        end else begin
            shadow_dropped = 1'b1;
        end
        if (it.last) begin
            for (int pos = 0; pos + 1 < shadow_count; pos++) begin
                best = pos;
                for (int p = pos + 1; p < shadow_count; p++) begin
                    if (shadow_store[p] < shadow_store[best]) best = p;
                end
                keep               = shadow_store[pos];
                shadow_store[pos]  = shadow_store[best];
                shadow_store[best] = keep;
            end
            for (int k = 0; k < shadow_count; k++) begin
                r.sorted_value = shadow_store[k];
                r.final_res    = (k == shadow_count - 1);
                r.overflowed   = shadow_dropped;
                res.push_back(r);
            end
            shadow_count   = 0;
            shadow_dropped = 1'b0;
        end
    endfunction

    // A mix of full-range values, extremes, zero, -1 and a narrow band for ties
    function automatic logic signed [selsort_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return VMAX;
            1: return VMIN;
            2: return 32'sd0;
            3: return -32'sd1;
            4, 5: return 32'(int'($urandom_range(15)) - 8);
            default: return $urandom;
        endcase
    endfunction

    // Offer one item, with random gaps before it; returns at the accepting edge
    task automatic send_item(input selsort_pkg::in_item_t it);
        while ($urandom_range(99) < tx_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_and_predict(input selsort_pkg::in_item_t it);
        selsort_pkg::out_item_t res[$];
        send_item(it);
        store_and_sort(it, res);
        foreach (res[i]) pending_sorted.push_back(res[i]);
    endtask

    // Receiver: random stalls, or one long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Result checking and watchdog
    always @(posedge aclk) begin : result_check
        selsort_pkg::out_item_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_sorted.size() == 0) begin
                    report_mismatch($sformatf("unexpected result item, value %0d",
                                              m_data.sorted_value));
                end else begin
                    want = pending_sorted.pop_front();
                    if (m_data.sorted_value !== want.sorted_value)
                        report_mismatch($sformatf("sorted_value got %0d want %0d",
                                                  m_data.sorted_value, want.sorted_value));
                    if (m_data.final_res !== want.final_res)
                        report_mismatch($sformatf("final_res got %0b want %0b",
                                                  m_data.final_res, want.final_res));
                    if (m_data.overflowed !== want.overflowed)
                        report_mismatch($sformatf("overflowed got %0b want %0b",
                                                  m_data.overflowed, want.overflowed));
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("Mismatches found");
                    $finish;
                end
            end
        end
    end

    // Stimulus
    initial begin
        selsort_pkg::in_item_t  it;
        selsort_pkg::out_item_t res[$];
        selsort_pkg::out_item_t known;
        int                     phase_sent;
        int                     blk_len;
        bit                     first_blk;

        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        tx_gap_pct     = 0;
        rx_stall_pct   = 0;
        hold_req       = 1'b0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        shadow_count   = 0;
        shadow_dropped = 1'b0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table
        foreach (directed_rows[i]) begin
            it.value = directed_rows[i].value;
            it.last  = directed_rows[i].last;
            send_item(it);
            store_and_sort(it, res);
            if (directed_rows[i].typed) begin
                known.sorted_value = directed_rows[i].typed_value;
                known.final_res    = 1'b1;
                known.overflowed   = 1'b0;
                pending_sorted.push_back(known);
            end else begin
                foreach (res[k]) pending_sorted.push_back(res[k]);
            end
        end

        // Random blocks under each idling mix
        for (int phase = 0; phase < N_PHASES; phase++) begin
            case (phase)
                0: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_gap_pct = 53; rx_stall_pct = 0;  end
                2: begin tx_gap_pct = 0;  rx_stall_pct = 53; end
                default: begin tx_gap_pct = 13; rx_stall_pct = 13; end
            endcase
            phase_sent = 0;
            first_blk  = 1'b1;
            while (phase_sent < RANDOM_ITEMS / N_PHASES) begin
                case ($urandom_range(19))
                    0, 1, 2:  blk_len = $urandom_range(CAP - 1, 9);
                    3, 4:     blk_len = CAP;
                    5:        blk_len = $urandom_range(CAP + 8, CAP + 1);
                    default:  blk_len = $urandom_range(8, 1);
                endcase
                if (first_blk) begin
                    // full block under a long receiver hold-off, then an overrun
                    if (phase == 0) begin
                        hold_req = 1'b1;
                        blk_len  = CAP;
                    end else if (phase == 1) begin
                        blk_len = CAP + 5;
                    end
                    first_blk = 1'b0;
                end
                for (int i = 0; i < blk_len; i++) begin
                    it.value = pick_value();
                    it.last  = (i == blk_len - 1);
                    send_and_predict(it);
                end
                phase_sent += blk_len;
            end
        end
        s_valid <= 1'b0;

        // Drain, then allow one more pass of the chain for stray results
        while (pending_sorted.size() != 0) @(posedge aclk);
        repeat (CAP + 8) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
